@@ src/tcsg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Tone generator package
// Shared constants, codes and controller/datapath link types for the
// three-channel square tone generator.
// ----------------------------------------------------------------------------
package tcsg_pkg;

    localparam int NUM_CHANNELS    = 3;
    localparam int MAX_TICK_CYCLES = 255;

    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DIV_W = 8;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Top three address bits select the bus port.
    localparam logic [2:0] PORT_SELECT = 3'b110;
    localparam logic [2:0] PORT_DATA   = 3'b111;

    // Register select codes.
    localparam logic [3:0] SEL_PERIOD_BASE = 4'h0;
    localparam logic [3:0] SEL_MASK        = 4'h7;
    localparam logic [3:0] SEL_VOLUME_BASE = 4'h8;

    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_TICK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAN,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic ch_pass;
        logic div_start;
        logic div_step;
        logic div_finish;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic ch_off;
        logic ch_wrap;
        logic ch_last;
        logic div_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

@@ src/tcsg_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying bus writes and ticks.
// ----------------------------------------------------------------------------
interface tcsg_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] address;
    logic [7:0]  value;
    logic [7:0]  cycles;

    modport source (output valid, output action, output address, output value,
                    output cycles, input ready);
    modport sink   (input valid, input action, input address, input value,
                    input cycles, output ready);
endinterface
`default_nettype wire

@@ src/tcsg_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying mixed audio samples.
// ----------------------------------------------------------------------------
interface tcsg_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

@@ src/tcsg_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Tone generator controller
// Sequences the channels of a tick through the shared divider and hands the
// mixed sample to the output register.
// ----------------------------------------------------------------------------
module tcsg_ctrl
    import tcsg_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && status.is_tick)
                begin
                    state_next = ST_CHAN;
                end
            end
            ST_CHAN:
            begin
                if (!status.ch_off && status.ch_wrap)
                begin
                    state_next = ST_DIV;
                end
                else if (status.ch_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_CHAN;
                end
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = status.ch_last ? ST_DONE : ST_CHAN;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.accept = item_valid;
            end
            ST_CHAN:
            begin
                if (!status.ch_off && status.ch_wrap)
                begin
                    cmd.div_start = 1'b1;
                end
                else
                begin
                    cmd.ch_pass = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_FIN:
            begin
                cmd.div_finish = 1'b1;
            end
            ST_DONE:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ src/tcsg_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Tone generator datapath
// Register file, per-channel counters and phases, a bit-serial divider for
// counter wrap-around, the mix accumulator and the output register.
// ----------------------------------------------------------------------------
module tcsg_datapath
    import tcsg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               action,
    input  wire logic [15:0]        address,
    input  wire logic [7:0]         value,
    input  wire logic [7:0]         cycles,
    input  wire cmd_t               cmd,
    output status_t                 status,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [14:0]      sample
);

    logic [3:0]              sel_reg, sel_next;
    logic [11:0]             period_reg [NUM_CHANNELS];
    logic [11:0]             period_next [NUM_CHANNELS];
    logic [3:0]              vol_reg [NUM_CHANNELS];
    logic [3:0]              vol_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] mask_reg, mask_next;
    logic [4:0]              phase_reg [NUM_CHANNELS];
    logic [4:0]              phase_next [NUM_CHANNELS];
    logic [12:0]             cnt_reg [NUM_CHANNELS];
    logic [12:0]             cnt_next [NUM_CHANNELS];
    logic [7:0]              cyc_reg, cyc_next;
    logic signed [8:0]       acc_reg, acc_next;
    logic [CH_W-1:0]         idx_reg, idx_next;
    logic [11:0]             rem_reg, rem_next;
    logic [DIV_W-1:0]        quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]    dcnt_reg, dcnt_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [14:0]      sample_reg, sample_next;

    logic [2:0]  port;
    logic [7:0]  cyc_sat;
    logic [11:0] cur_period;
    logic [3:0]  cur_vol;
    logic [4:0]  cur_phase;
    logic [12:0] cur_cnt;
    logic [12:0] reload;
    logic [7:0]  deficit;
    logic [12:0] trial;
    logic        trial_ge;
    logic [4:0]  wrap_phase;
    logic [5:0]  vol3;
    logic        mix_bit;
    logic signed [8:0] mix_sum;

    assign port       = address[15:13];
    assign cyc_sat    = (int'(cycles) > MAX_TICK_CYCLES) ? 8'(MAX_TICK_CYCLES) : cycles;
    assign cur_period = period_reg[idx_reg];
    assign cur_vol    = vol_reg[idx_reg];
    assign cur_phase  = phase_reg[idx_reg];
    assign cur_cnt    = cnt_reg[idx_reg];
    assign reload     = {1'b0, cur_period} + 13'd1;
    assign deficit    = cyc_reg - cur_cnt[7:0];
    assign trial      = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_ge   = (trial >= reload);
    assign wrap_phase = cur_phase + quo_reg[4:0] + 5'd1;
    assign vol3       = {1'b0, cur_vol, 1'b0} + {2'b00, cur_vol};

    // The divider leaves the wrapped phase only after its last step, so the
    // sign of a wrapped channel comes from the updated phase.
    assign mix_bit = cmd.div_finish ? wrap_phase[4] : cur_phase[4];
    assign mix_sum = mix_bit ? (acc_reg + $signed({3'b000, vol3}))
                             : (acc_reg - $signed({3'b000, vol3}));

    always_comb
    begin
        status.is_tick  = (action == ACTION_TICK);
        status.ch_off   = mask_reg[idx_reg];
        status.ch_wrap  = ({5'd0, cyc_reg} >= cur_cnt);
        status.ch_last  = (idx_reg == CH_W'(NUM_CHANNELS - 1));
        status.div_last = (dcnt_reg == DIV_CNT_W'(DIV_W - 1));
        status.out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        sel_next       = sel_reg;
        period_next    = period_reg;
        vol_next       = vol_reg;
        mask_next      = mask_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        cyc_next       = cyc_reg;
        acc_next       = acc_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.accept)
        begin
            cyc_next = cyc_sat;
            acc_next = '0;
            idx_next = '0;
            if (action == ACTION_WRITE)
            begin
                if (port == PORT_SELECT)
                begin
                    sel_next = value[3:0];
                end
                else if (port == PORT_DATA)
                begin
                    if (sel_reg == SEL_MASK)
                    begin
                        mask_next = value[NUM_CHANNELS-1:0];
                    end
                    for (int c = 0; c < NUM_CHANNELS; c++)
                    begin
                        if (sel_reg == SEL_PERIOD_BASE + 4'(2 * c))
                        begin
                            period_next[c][7:0] = value;
                        end
                        if (sel_reg == SEL_PERIOD_BASE + 4'(2 * c + 1))
                        begin
                            period_next[c][11:8] = value[3:0];
                        end
                        if (sel_reg == SEL_VOLUME_BASE + 4'(c))
                        begin
                            vol_next[c] = value[3:0];
                        end
                    end
                end
            end
        end

        if (cmd.ch_pass)
        begin
            if (!mask_reg[idx_reg])
            begin
                cnt_next[idx_reg] = cur_cnt - {5'd0, cyc_reg};
                acc_next          = mix_sum;
            end
            idx_next = idx_reg + CH_W'(1);
        end

        if (cmd.div_start)
        begin
            rem_next  = '0;
            quo_next  = deficit;
            dcnt_next = '0;
        end

        if (cmd.div_step)
        begin
            rem_next  = trial_ge ? 12'(trial - reload) : trial[11:0];
            quo_next  = {quo_reg[DIV_W-2:0], trial_ge};
            dcnt_next = dcnt_reg + DIV_CNT_W'(1);
        end

        if (cmd.div_finish)
        begin
            cnt_next[idx_reg]   = reload - {1'b0, rem_reg};
            phase_next[idx_reg] = wrap_phase;
            acc_next            = mix_sum;
            idx_next            = idx_reg + CH_W'(1);
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            sample_next    = {acc_reg, 6'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            dcnt_reg      <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                period_reg[c] <= '0;
                vol_reg[c]    <= '0;
                phase_reg[c]  <= '0;
                cnt_reg[c]    <= 13'd1;
            end
        end
        else
        begin
            sel_reg       <= sel_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            dcnt_reg      <= dcnt_next;
            period_reg    <= period_next;
            vol_reg       <= vol_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cyc_reg    <= cyc_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        sample_reg <= sample_next;
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

endmodule
`default_nettype wire

@@ src/three_channel_square_tone_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Three-channel square tone generator
// Bus words written to the select port (address top bits 110) pick a register;
// words written to the data port (top bits 111) load it. A tick word advances
// every enabled channel and yields one mixed sample. Each enabled channel
// whose counter runs out goes through the 8-step bit-serial divider that
// finds the number of phase steps; the other channels of the tick pass on.
// A finished sample waits in an output register while the next bus write is
// taken.
// ----------------------------------------------------------------------------
module three_channel_square_tone_generator
    import tcsg_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tcsg_in_if.sink    item,
    tcsg_out_if.source result
);

    cmd_t    cmd;
    status_t status;

    tcsg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .status     (status),
        .cmd        (cmd)
    );

    tcsg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .action    (item.action),
        .address   (item.address),
        .value     (item.value),
        .cycles    (item.cycles),
        .cmd       (cmd),
        .status    (status),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sample    (result.sample)
    );

endmodule
`default_nettype wire
